// File: hw/rtl/timer_min_queue_macros.svh
// Assertion helpers for the timer min queue.
`ifndef TIMER_MIN_QUEUE_MACROS_SVH
`define TIMER_MIN_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define TMQ_ASSERT(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("timer_min_queue assertion failed");
// Implication: antecedent at one edge, consequent at the next edge.
`define TMQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer_min_queue assertion failed");
`else
`define TMQ_ASSERT(name, clk, rst_n, cond)
`define TMQ_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/tmq_pkg.sv
`timescale 1ns / 1ps

package tmq_pkg;

    localparam int TMQ_MAX_ENTRIES = 16;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [8:0] MODULE_NONE = 9'h1FF;

    typedef struct packed {
        logic [63:0] deadline;
        logic [7:0]  module_id;
        logic [15:0] tag;
    } entry_t;

    typedef struct packed {
        logic valid;   // read data from the store is present
        logic first;   // that data belongs to entry zero
    } cmp_ctrl_t;

endpackage

// File: hw/rtl/tmq_ram.sv
`timescale 1ns / 1ps

module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tmq_min_unit.sv
`timescale 1ns / 1ps

module tmq_min_unit import tmq_pkg::*; #(
    parameter int IDX_W = 4
) (
    input  logic             aclk,
    input  cmp_ctrl_t        ctrl,
    input  logic [IDX_W-1:0] idx,
    input  entry_t           entry,
    output entry_t           best,
    output logic [IDX_W-1:0] best_idx
);

    entry_t           best_reg;
    entry_t           best_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    logic             take;

    // Strict less-than keeps the earliest inserted entry on a tie.
    always_comb begin
        take          = ctrl.valid && (ctrl.first || (entry.deadline < best_reg.deadline));
        best_next     = take ? entry : best_reg;
        best_idx_next = take ? idx : best_idx_reg;
    end

    always_ff @(posedge aclk) begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

endmodule

// File: hw/rtl/timer_min_queue.sv
`timescale 1ns / 1ps
`include "timer_min_queue_macros.svh"

// Timer queue holding up to MAX_ENTRIES entries in insertion order in a
// single-port-read RAM. A get request reads the stored entries with one
// RAM read per cycle, which feeds a shared comparator to find the minimum;
// unless the soonest deadline is zero or the soonest is the last entry, the
// same read port then moves the entries behind it up one place each cycle.
// A get on an empty store or a flush by a zero deadline finishes without
// the move. The next request is taken once the current one has produced
// its result, even while that result still waits in the output register.
module timer_min_queue import tmq_pkg::*; #(
    parameter int MAX_ENTRIES = TMQ_MAX_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [63:0]       s_deadline,
    input  logic [7:0]        s_module_id,
    input  logic [15:0]       s_payload_tag,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [63:0]       m_out_deadline,
    output logic signed [8:0] m_out_module,
    output logic [15:0]       m_out_tag,
    output logic              m_flushed
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] rd_at_reg, rd_at_next;
    logic             rd_vld_reg, rd_vld_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic [63:0] res_dl_reg, res_dl_next;
    logic [8:0]  res_mod_reg, res_mod_next;
    logic [15:0] res_tag_reg, res_tag_next;
    logic        res_fl_reg, res_fl_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [63:0] m_dl_reg, m_dl_next;
    logic [8:0]  m_mod_reg, m_mod_next;
    logic [15:0] m_tag_reg, m_tag_next;
    logic        m_fl_reg, m_fl_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata_raw;
    entry_t           ram_rdata;

    cmp_ctrl_t        cmp_ctrl;
    entry_t           best;
    logic [IDX_W-1:0] best_idx;

    logic             issue;
    logic             last_data;
    logic [IDX_W-1:0] last_idx;

    tmq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    tmq_min_unit #(
        .IDX_W (IDX_W)
    ) u_min (
        .aclk     (aclk),
        .ctrl     (cmp_ctrl),
        .idx      (rd_at_reg),
        .entry    (ram_rdata),
        .best     (best),
        .best_idx (best_idx)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_deadline = m_dl_reg;
    assign m_out_module   = $signed(m_mod_reg);
    assign m_out_tag      = m_tag_reg;
    assign m_flushed      = m_fl_reg;

    assign cmp_ctrl.valid = (state_reg == ST_SCAN) && rd_vld_reg;
    assign cmp_ctrl.first = (rd_at_reg == '0);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_dl_next     = res_dl_reg;
        res_mod_next    = res_mod_reg;
        res_tag_next    = res_tag_reg;
        res_fl_next     = res_fl_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_dl_next     = m_dl_reg;
        m_mod_next    = m_mod_reg;
        m_tag_next    = m_tag_reg;
        m_fl_next     = m_fl_reg;

        last_idx  = IDX_W'(count_reg - CNT_W'(1));
        last_data = rd_vld_reg && (rd_at_reg == last_idx);

        // One read a cycle while scanning or moving entries up.
        issue       = ((state_reg == ST_SCAN) || (state_reg == ST_SHIFT)) &&
                      (rd_idx_reg < count_reg);
        rd_idx_next = issue ? (rd_idx_reg + CNT_W'(1)) : rd_idx_reg;
        rd_vld_next = issue;
        rd_at_next  = issue ? rd_idx_reg[IDX_W-1:0] : rd_at_reg;
        ram_raddr   = rd_idx_reg[IDX_W-1:0];

        ram_we    = 1'b0;
        ram_waddr = rd_at_reg - IDX_W'(1);
        ram_wdata = ram_rdata;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_dl_next  = '0;
                    res_mod_next = '0;
                    res_tag_next = '0;
                    res_fl_next  = 1'b0;
                    if (s_op == OP_ADD) begin
                        if (count_reg == CNT_W'(MAX_ENTRIES)) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            ram_we             = 1'b1;
                            ram_waddr          = count_reg[IDX_W-1:0];
                            ram_wdata.deadline  = s_deadline;
                            ram_wdata.module_id = s_module_id;
                            ram_wdata.tag       = s_payload_tag;
                            count_next         = count_reg + CNT_W'(1);
                            res_status_next    = STATUS_OK;
                        end
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        res_status_next = STATUS_EMPTY;
                        res_mod_next    = MODULE_NONE;
                        state_next      = ST_DONE;
                    end else begin
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (last_data) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                res_status_next = STATUS_OK;
                res_mod_next    = {1'b0, best.module_id};
                res_tag_next    = best.tag;
                if (best.deadline == '0) begin
                    // Drop every entry.
                    count_next  = '0;
                    res_dl_next = '0;
                    res_fl_next = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    res_dl_next = best.deadline;
                    res_fl_next = 1'b0;
                    if (best_idx == last_idx) begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_DONE;
                    end else begin
                        rd_idx_next = CNT_W'(best_idx) + CNT_W'(1);
                        state_next  = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                // Write each entry read back one place lower.
                if (rd_vld_reg) begin
                    ram_we = 1'b1;
                end
                if (last_data) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_dl_next     = res_dl_reg;
                    m_mod_next    = res_mod_reg;
                    m_tag_next    = res_tag_reg;
                    m_fl_next     = res_fl_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        rd_at_reg      <= rd_at_next;
        res_status_reg <= res_status_next;
        res_dl_reg     <= res_dl_next;
        res_mod_reg    <= res_mod_next;
        res_tag_reg    <= res_tag_next;
        res_fl_reg     <= res_fl_next;
        m_status_reg   <= m_status_next;
        m_dl_reg       <= m_dl_next;
        m_mod_reg      <= m_mod_next;
        m_tag_reg      <= m_tag_next;
        m_fl_reg       <= m_fl_next;
    end

    `TMQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_ENTRIES))
    `TMQ_ASSERT_NEXT(a_add_grows, aclk, aresetn,
        s_valid && s_ready && (s_op == OP_ADD) && (count_reg < CNT_W'(MAX_ENTRIES)),
        count_reg == $past(count_reg) + CNT_W'(1))
    `TMQ_ASSERT(a_shift_addr, aclk, aresetn,
        !((state_reg == ST_SHIFT) && rd_vld_reg) || (rd_at_reg != '0))
    `TMQ_ASSERT(a_flush_zero, aclk, aresetn,
        !(m_valid_reg && m_fl_reg) || (m_dl_reg == '0))

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tmq_pkg::*;

    typedef struct {
        logic        op;
        logic [63:0] deadline;
        logic [7:0]  module_id;
        logic [15:0] tag;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] deadline;
        logic [8:0]  module_id;
        logic [15:0] tag;
        logic        flushed;
    } reply_t;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int DRAIN_CYCLES    = 50;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_op          = OP_ADD;
    logic [63:0]       s_deadline    = '0;
    logic [7:0]        s_module_id   = '0;
    logic [15:0]       s_payload_tag = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [1:0]        m_status;
    logic [63:0]       m_out_deadline;
    logic signed [8:0] m_out_module;
    logic [15:0]       m_out_tag;
    logic              m_flushed;

    request_t pending_requests[$];
    reply_t   expected_replies[$];

    // Timer store as it should look after every accepted request
    logic [63:0] timer_deadline[TMQ_MAX_ENTRIES];
    logic [7:0]  timer_module[TMQ_MAX_ENTRIES];
    logic [15:0] timer_tag[TMQ_MAX_ENTRIES];
    int          model_count = 0;

    int fail_count  = 0;
    int reply_count = 0;
    int src_gap     = 0;
    int src_calm    = 0;
    int sink_stall  = 0;
    int sink_calm   = 0;

    timer_min_queue dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_deadline    (s_deadline),
        .s_module_id   (s_module_id),
        .s_payload_tag (s_payload_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_deadline(m_out_deadline),
        .m_out_module  (m_out_module),
        .m_out_tag     (m_out_tag),
        .m_flushed     (m_flushed)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        fail_count++;
    endtask

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if (roll < 2) begin
            calm = $urandom_range(30, 80);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Apply one accepted request to the timer store and queue the reply it yields.
    task automatic apply_timer_request(input logic op, input logic [63:0] deadline,
                                       input logic [7:0] module_id, input logic [15:0] tag);
        reply_t r;
        int     best;
        r = '{status: STATUS_OK, deadline: '0, module_id: '0, tag: '0, flushed: 1'b0};
        if (op == OP_ADD) begin
            if (model_count >= TMQ_MAX_ENTRIES) begin
                r.status = STATUS_FULL;
            end else begin
                timer_deadline[model_count] = deadline;
                timer_module[model_count]   = module_id;
                timer_tag[model_count]      = tag;
                model_count++;
            end
        end else if (model_count == 0) begin
            r.status    = STATUS_EMPTY;
            r.module_id = MODULE_NONE;
        end else begin
            best = 0;
            // strict compare keeps the earliest insert on a tie
            for (int i = 1; i < model_count; i++) begin
                if (timer_deadline[i] < timer_deadline[best]) best = i;
            end
            r.module_id = {1'b0, timer_module[best]};
            r.tag       = timer_tag[best];
            if (timer_deadline[best] == 64'd0) begin
                r.flushed   = 1'b1;
                model_count = 0;
            end else begin
                r.deadline = timer_deadline[best];
                for (int i = best; i < model_count - 1; i++) begin
                    timer_deadline[i] = timer_deadline[i + 1];
                    timer_module[i]   = timer_module[i + 1];
                    timer_tag[i]      = timer_tag[i + 1];
                end
                model_count--;
            end
        end
        expected_replies.push_back(r);
    endtask

    task automatic queue_request(input logic op, input logic [63:0] deadline,
                                 input logic [7:0] module_id, input logic [15:0] tag);
        request_t req;
        req.op        = op;
        req.deadline  = deadline;
        req.module_id = module_id;
        req.tag       = tag;
        pending_requests.push_back(req);
    endtask

    // Zero is rare so the store can fill; small values make ties likely.
    function automatic logic [63:0] random_deadline();
        int roll;
        roll = $urandom_range(0, 31);
        if (roll == 0) return 64'd0;
        if (roll < 12) return 64'($urandom_range(1, 8));
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random(input logic op);
        queue_request(op, random_deadline(), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)));
    endtask

    always @(posedge aclk) begin : drive_requests
        request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_timer_request(s_op, s_deadline, s_module_id, s_payload_tag);
            end
            // hold the request until it is taken
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    s_op          <= req.op;
                    s_deadline    <= req.deadline;
                    s_module_id   <= req.module_id;
                    s_payload_tag <= req.tag;
                    s_valid       <= 1'b1;
                    src_gap = pick_gap(src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("reply with no request pending", {62'd0, m_status}, '0);
                end else begin
                    want = expected_replies.pop_front();
                    reply_count++;
                    if (m_status !== want.status)
                        report_mismatch("status", {62'd0, m_status}, {62'd0, want.status});
                    if (m_out_deadline !== want.deadline)
                        report_mismatch("deadline", m_out_deadline, want.deadline);
                    if (m_out_module !== want.module_id)
                        report_mismatch("module", {55'd0, m_out_module}, {55'd0, want.module_id});
                    if (m_out_tag !== want.tag)
                        report_mismatch("tag", {48'd0, m_out_tag}, {48'd0, want.tag});
                    if (m_flushed !== want.flushed)
                        report_mismatch("flushed", {63'd0, m_flushed}, {63'd0, want.flushed});
                end
                sink_stall = pick_gap(sink_calm);
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int planned;
        int burst;
        int total;
        logic [63:0] far;
        far = '1;

        // empty get, then a zero deadline on its own
        queue_request(OP_GET, far, 8'hFF, 16'hFFFF);
        queue_request(OP_ADD, 64'd0, 8'h00, 16'h0000);
        queue_request(OP_GET, 64'd0, 8'h00, 16'h0000);
        // extremes and a tie on the deadline
        queue_request(OP_ADD, far, 8'hFF, 16'hFFFF);
        queue_request(OP_ADD, 64'd5, 8'h01, 16'h0001);
        queue_request(OP_ADD, 64'd5, 8'h02, 16'h0002);
        queue_request(OP_GET, far, 8'h55, 16'h5555);
        queue_request(OP_GET, 64'd0, 8'hAA, 16'hAAAA);
        queue_request(OP_GET, 64'd1, 8'h00, 16'h0000);
        queue_request(OP_GET, 64'd0, 8'h00, 16'h0000);
        // zero deadline in the middle drops the others
        queue_request(OP_ADD, 64'd9, 8'h03, 16'h0003);
        queue_request(OP_ADD, 64'd0, 8'h04, 16'h0004);
        queue_request(OP_ADD, 64'd7, 8'h05, 16'h0005);
        queue_request(OP_GET, 64'd0, 8'h00, 16'h0000);
        queue_request(OP_GET, 64'd0, 8'h00, 16'h0000);

        planned = 0;
        while (planned < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 3))
                0: begin
                    // fill past the top to hit the full store
                    burst = $urandom_range(8, 20);
                    repeat (burst) queue_random(OP_ADD);
                end
                1: begin
                    burst = $urandom_range(4, 20);
                    repeat (burst) queue_random(OP_GET);
                end
                default: begin
                    burst = $urandom_range(10, 30);
                    repeat (burst) queue_random(($urandom_range(0, 9) < 6) ? OP_ADD : OP_GET);
                end
            endcase
            planned += burst;
        end
        total = pending_requests.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // every request yields one reply; wait until all of them are checked
        while (reply_count < total) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(8_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
